@@ src/blhir_pkg.sv @@
// Shared types and constants for the bounded head-insert list block.
// Used by blhir_ctrl, blhir_dp and the top level bounded_list_head_insert_remove.
package blhir_pkg;

    // List capacity and the widths that follow from it.
    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Input command codes.
    typedef enum logic [1:0] {
        CMD_INSERT    = 2'd0,
        CMD_REMOVE    = 2'd1,
        CMD_SHOW_FWD  = 2'd2,
        CMD_SHOW_REV  = 2'd3
    } cmd_t;

    // Result status codes.
    typedef enum logic [2:0] {
        STS_INSERTED  = 3'd0,
        STS_REMOVED   = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_EMPTY     = 3'd3,
        STS_FULL      = 3'd4,
        STS_LISTED    = 3'd5
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // Latch the accepted input beat.
        logic exec;       // Carry out the latched command.
        logic show_step;  // Emit the next listed element.
    } dp_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_show;    // Latched command is a show.
        logic empty;      // List holds no entries.
        logic out_free;   // Output register can take a beat this cycle.
        logic show_last;  // Current show element is the final one.
    } dp_stat_t;

endpackage

@@ src/blhir_ctrl.sv @@
// Controller state machine for the bounded head-insert list block.
// Depends on blhir_pkg for the command and status structs.
module blhir_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  blhir_pkg::dp_stat_t stat,
    output blhir_pkg::dp_ctrl_t ctrl
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_SHOW = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Input is taken only while no command is in flight.
    assign s_ready = (state_reg == ST_IDLE);

    // Next state and datapath commands.
    always_comb begin
        state_next     = state_reg;
        ctrl.capture   = 1'b0;
        ctrl.exec      = 1'b0;
        ctrl.show_step = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.out_free) begin
                    ctrl.exec = 1'b1;
                    if (stat.is_show && !stat.empty) begin
                        state_next = ST_SHOW;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SHOW: begin
                if (stat.out_free) begin
                    ctrl.show_step = 1'b1;
                    if (stat.show_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/blhir_dp.sv @@
// Datapath for the bounded head-insert list block: entry cells, entry count,
// show counter and the output register. Depends on blhir_pkg.
module blhir_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  blhir_pkg::dp_ctrl_t                   ctrl,
    output blhir_pkg::dp_stat_t                   stat,
    input  logic [1:0]                            s_command,
    input  logic signed [blhir_pkg::DATA_W-1:0]   s_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [2:0]                            m_status,
    output logic signed [blhir_pkg::DATA_W-1:0]   m_item_value,
    output logic [3:0]                            m_position,
    output logic [4:0]                            m_entry_total,
    output logic                                  m_last
);

    // Latched input beat.
    blhir_pkg::cmd_t                   cmd_reg;
    logic [blhir_pkg::DATA_W-1:0]      val_reg;

    // Entry cells: cell 0 is the head.
    logic [blhir_pkg::DATA_W-1:0]      cell_reg  [blhir_pkg::CAPACITY];
    logic [blhir_pkg::DATA_W-1:0]      cell_next [blhir_pkg::CAPACITY];
    logic [blhir_pkg::CNT_W-1:0]       count_reg;
    logic [blhir_pkg::CNT_W-1:0]       count_next;

    // Show walk counter.
    logic [blhir_pkg::CNT_W-1:0]       show_k_reg;
    logic [blhir_pkg::CNT_W-1:0]       show_idx;

    // Remove search.
    logic [blhir_pkg::CAPACITY-1:0]    hit;
    logic [blhir_pkg::CAPACITY-1:0]    shift_en;
    logic                              any_hit;

    // Output register.
    logic                              m_valid_reg;
    blhir_pkg::status_t                status_reg;
    logic [blhir_pkg::DATA_W-1:0]      item_reg;
    logic [blhir_pkg::IDX_W-1:0]       pos_reg;
    logic [blhir_pkg::CNT_W-1:0]       total_reg;
    logic                              last_reg;

    logic                              empty;
    logic                              full;
    logic                              is_show;
    logic                              exec_load;
    blhir_pkg::status_t                exec_status;
    logic [blhir_pkg::CNT_W-1:0]       exec_total;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == blhir_pkg::CNT_W'(blhir_pkg::CAPACITY));
    assign is_show = (cmd_reg == blhir_pkg::CMD_SHOW_FWD) ||
                     (cmd_reg == blhir_pkg::CMD_SHOW_REV);

    // Status back to the controller.
    assign stat.is_show   = is_show;
    assign stat.empty     = empty;
    assign stat.out_free  = !m_valid_reg || m_ready;
    assign stat.show_last = ((show_k_reg + blhir_pkg::CNT_W'(1)) == count_reg);

    // Capture the input beat.
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            cmd_reg <= blhir_pkg::cmd_t'(s_command);
            val_reg <= s_value;
        end
    end

    // Compare every live cell against the search value and mark the cells
    // from the first match toward the tail, which close the gap.
    always_comb begin : remove_search
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < blhir_pkg::CAPACITY; i++) begin
            hit[i]      = (cell_reg[i] == val_reg) &&
                          (blhir_pkg::CNT_W'(i) < count_reg);
            seen        = seen | hit[i];
            shift_en[i] = seen;
        end
        any_hit = seen;
    end

    // Next cell contents: shift toward the tail on insert, toward the head
    // above the match on remove.
    always_comb begin
        for (int i = 0; i < blhir_pkg::CAPACITY; i++) begin
            cell_next[i] = cell_reg[i];
        end
        if (ctrl.exec && cmd_reg == blhir_pkg::CMD_INSERT && !full) begin
            cell_next[0] = val_reg;
            for (int i = 1; i < blhir_pkg::CAPACITY; i++) begin
                cell_next[i] = cell_reg[i-1];
            end
        end else if (ctrl.exec && cmd_reg == blhir_pkg::CMD_REMOVE && any_hit) begin
            for (int i = 0; i < blhir_pkg::CAPACITY - 1; i++) begin
                if (shift_en[i]) begin
                    cell_next[i] = cell_reg[i+1];
                end
            end
        end
    end

    // Status beat, new entry count and total for an executed command.
    always_comb begin
        exec_load   = 1'b1;
        exec_status = blhir_pkg::STS_EMPTY;
        exec_total  = '0;
        count_next  = count_reg;
        case (cmd_reg)
            blhir_pkg::CMD_INSERT: begin
                if (full) begin
                    exec_status = blhir_pkg::STS_FULL;
                    exec_total  = count_reg;
                end else begin
                    exec_status = blhir_pkg::STS_INSERTED;
                    exec_total  = count_reg + blhir_pkg::CNT_W'(1);
                    count_next  = count_reg + blhir_pkg::CNT_W'(1);
                end
            end
            blhir_pkg::CMD_REMOVE: begin
                if (empty) begin
                    exec_status = blhir_pkg::STS_EMPTY;
                end else if (any_hit) begin
                    exec_status = blhir_pkg::STS_REMOVED;
                    exec_total  = count_reg - blhir_pkg::CNT_W'(1);
                    count_next  = count_reg - blhir_pkg::CNT_W'(1);
                end else begin
                    exec_status = blhir_pkg::STS_NOT_FOUND;
                    exec_total  = count_reg;
                end
            end
            default: begin
                // A show on a non-empty list gives its beats in the walk.
                exec_load = empty;
            end
        endcase
        if (!ctrl.exec) begin
            count_next = count_reg;
        end
    end

    // Cells and entry count.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < blhir_pkg::CAPACITY; i++) begin
            cell_reg[i] <= cell_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Show walk: forward goes head to tail, reverse tail to head.
    assign show_idx = (cmd_reg == blhir_pkg::CMD_SHOW_FWD) ? show_k_reg :
                      (count_reg - blhir_pkg::CNT_W'(1) - show_k_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.exec) begin
            show_k_reg <= '0;
        end else if (ctrl.show_step) begin
            show_k_reg <= show_k_reg + blhir_pkg::CNT_W'(1);
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((ctrl.exec && exec_load) || ctrl.show_step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (ctrl.exec && exec_load) begin
            status_reg <= exec_status;
            item_reg   <= '0;
            pos_reg    <= '0;
            total_reg  <= exec_total;
            last_reg   <= 1'b1;
        end else if (ctrl.show_step) begin
            status_reg <= blhir_pkg::STS_LISTED;
            item_reg   <= cell_reg[show_idx[blhir_pkg::IDX_W-1:0]];
            pos_reg    <= show_idx[blhir_pkg::IDX_W-1:0];
            total_reg  <= count_reg;
            last_reg   <= stat.show_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_item_value  = item_reg;
    assign m_position    = pos_reg;
    assign m_entry_total = total_reg;
    assign m_last        = last_reg;

endmodule

@@ src/bounded_list_head_insert_remove.sv @@
// Top level of the bounded head-insert list: joins the controller and datapath.
// Depends on blhir_pkg, blhir_ctrl and blhir_dp.
//
//  Channel  Ports                                              Handshake
//  input    s_command, s_value                                 s_valid / s_ready
//  result   m_status, m_item_value, m_position,                m_valid / m_ready
//           m_entry_total, m_last
//
// Insert and remove take the beat when idle, then execute once the output register
// is free: all sixteen cells compare against the value and shift in parallel.
// A show is taken, then walks the entries; the output register gives one listed
// element a cycle while m_ready allows. An empty show gives a single status beat.
// Reset clears the entry count and the control state; cells need no clear.
// A stalled result channel holds the controller until the output register frees.
module bounded_list_head_insert_remove (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_command,
    input  logic signed [blhir_pkg::DATA_W-1:0]   s_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [2:0]                            m_status,
    output logic signed [blhir_pkg::DATA_W-1:0]   m_item_value,
    output logic [3:0]                            m_position,
    output logic [4:0]                            m_entry_total,
    output logic                                  m_last
);

    blhir_pkg::dp_ctrl_t ctrl;
    blhir_pkg::dp_stat_t stat;

    // Sequencing of each command.
    blhir_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // Cells, count and result register.
    blhir_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .stat          (stat),
        .s_command     (s_command),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_item_value  (m_item_value),
        .m_position    (m_position),
        .m_entry_total (m_entry_total),
        .m_last        (m_last)
    );

endmodule

@@ tb/sv/bounded_list_head_insert_remove_test.sv @@
// Self-checking testbench for bounded_list_head_insert_remove: drives command beats and
// checks every result beat against a scoreboard that predicts the list contents.
// Depends on blhir_pkg and the bounded_list_head_insert_remove RTL.
`timescale 1ns / 100ps

module bounded_list_head_insert_remove_test;

    import blhir_pkg::*;

    localparam int          POOL_N       = 6;
    localparam int          RANDOM_BEATS = 58;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    // One result beat, field by field.
    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] item_value;
        logic [3:0]               position;
        logic [4:0]               entry_total;
        logic                     is_last;
    } outcome_t;

    // Scoreboard: keeps its own copy of the list and the outcomes still owed.
    class list_scoreboard;
        logic signed [DATA_W-1:0] held [CAPACITY];
        int unsigned              held_count = 0;
        outcome_t                 pending_outcomes [$];
        int unsigned              mismatches = 0;

        function void queue_outcome(status_t status, logic signed [DATA_W-1:0] item_value,
                                    int unsigned position, logic is_last);
            outcome_t o;
            o.status      = status;
            o.item_value  = item_value;
            o.position    = 4'(position);
            o.entry_total = 5'(held_count);
            o.is_last     = is_last;
            pending_outcomes.push_back(o);
        endfunction

        // Returns one of the values now held, for removes that should hit.
        function logic signed [DATA_W-1:0] pick_held();
            return held[$urandom_range(held_count - 1)];
        endfunction

        // Applies an accepted command beat to the list and queues its outcomes.
        function void note_command(cmd_t cmd, logic signed [DATA_W-1:0] val);
            int found_at;
            int unsigned idx;
            found_at = -1;
            case (cmd)
                CMD_INSERT: begin
                    if (held_count >= CAPACITY) begin
                        queue_outcome(STS_FULL, '0, 0, 1'b1);
                    end else begin
                        for (int i = held_count; i > 0; i--) held[i] = held[i-1];
                        held[0] = val;
                        held_count++;
                        queue_outcome(STS_INSERTED, '0, 0, 1'b1);
                    end
                end
                CMD_REMOVE: begin
                    if (held_count == 0) begin
                        queue_outcome(STS_EMPTY, '0, 0, 1'b1);
                    end else begin
                        for (int i = 0; i < held_count; i++) begin
                            if (found_at < 0 && held[i] == val) found_at = i;
                        end
                        if (found_at < 0) begin
                            queue_outcome(STS_NOT_FOUND, '0, 0, 1'b1);
                        end else begin
                            for (int j = found_at; j + 1 < held_count; j++) held[j] = held[j+1];
                            held_count--;
                            queue_outcome(STS_REMOVED, '0, 0, 1'b1);
                        end
                    end
                end
                default: begin
                    // Both show directions; position always counts from the head.
                    if (held_count == 0) begin
                        queue_outcome(STS_EMPTY, '0, 0, 1'b1);
                    end else begin
                        for (int unsigned i = 0; i < held_count; i++) begin
                            idx = (cmd == CMD_SHOW_FWD) ? i : held_count - 1 - i;
                            queue_outcome(STS_LISTED, held[idx], idx, i + 1 == held_count);
                        end
                    end
                end
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // Compares one accepted result beat with the oldest outcome owed.
        task check_outcome(outcome_t got);
            outcome_t want;
            if (pending_outcomes.size() == 0) begin
                report_mismatch($sformatf("unexpected result, status %0d", got.status));
            end else begin
                want = pending_outcomes.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.item_value !== want.item_value)
                    report_mismatch($sformatf("item_value %0d, want %0d",
                                              got.item_value, want.item_value));
                if (got.position !== want.position)
                    report_mismatch($sformatf("position %0d, want %0d",
                                              got.position, want.position));
                if (got.entry_total !== want.entry_total)
                    report_mismatch($sformatf("entry_total %0d, want %0d",
                                              got.entry_total, want.entry_total));
                if (got.is_last !== want.is_last)
                    report_mismatch($sformatf("last %0b, want %0b", got.is_last, want.is_last));
            end
        endtask
    endclass

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_command     = CMD_INSERT;
    logic signed [DATA_W-1:0] s_value       = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic [2:0]               m_status;
    logic signed [DATA_W-1:0] m_item_value;
    logic [3:0]               m_position;
    logic [4:0]               m_entry_total;
    logic                     m_last;

    int unsigned              send_idle_pct  = 0;
    int unsigned              recv_stall_pct = 0;
    int unsigned              cycle_count    = 0;
    logic signed [DATA_W-1:0] value_pool [POOL_N];
    list_scoreboard           board;

    bounded_list_head_insert_remove u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_item_value  (m_item_value),
        .m_position    (m_position),
        .m_entry_total (m_entry_total),
        .m_last        (m_last)
    );

    always #4 aclk = ~aclk;

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: check each accepted beat, then choose ready for the next edge.
    initial begin
        outcome_t got;
        board = new;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.status      = status_t'(m_status);
                got.item_value  = m_item_value;
                got.position    = m_position;
                got.entry_total = m_entry_total;
                got.is_last     = m_last;
                board.check_outcome(got);
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Sends one command beat, with random idle cycles ahead of it.
    // Valid is only lowered inside an idle gap, so back-to-back beats keep it high.
    task automatic send_command(input cmd_t cmd, input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_value   <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_command(cmd, val);
    endtask

    // Random traffic that keeps the list moving between empty and full.
    task automatic run_random(input int unsigned beats);
        int unsigned              roll;
        int unsigned              pick;
        int unsigned              insert_cut;
        cmd_t                     cmd;
        logic signed [DATA_W-1:0] val;
        repeat (beats) begin
            insert_cut = (board.held_count < 4) ? 60 : (board.held_count > 12) ? 25 : 40;
            roll = $urandom_range(99);
            if (roll < insert_cut)           cmd = CMD_INSERT;
            else if (roll < insert_cut + 35) cmd = CMD_REMOVE;
            else if (roll[0])                cmd = CMD_SHOW_FWD;
            else                             cmd = CMD_SHOW_REV;
            // Mostly values already held or from a small pool, so removes hit
            // and duplicates appear; the rest are arbitrary and usually miss.
            pick = $urandom_range(99);
            if (pick < 20)
                val = $urandom;
            else if (cmd == CMD_REMOVE && pick < 80 && board.held_count > 0)
                val = board.pick_held();
            else
                val = value_pool[$urandom_range(POOL_N - 1)];
            send_command(cmd, val);
        end
    endtask

    initial begin
        foreach (value_pool[k]) value_pool[k] = $urandom;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty list, value extremes, duplicates, miss, full list.
        send_command(CMD_SHOW_FWD, 32'sd0);
        send_command(CMD_SHOW_REV, 32'sd0);
        send_command(CMD_REMOVE, 32'sd7);
        send_command(CMD_INSERT, 32'sh8000_0000);
        send_command(CMD_INSERT, 32'sh7fff_ffff);
        send_command(CMD_INSERT, 32'sd0);
        send_command(CMD_INSERT, -32'sd1);
        send_command(CMD_INSERT, -32'sd1);
        send_command(CMD_REMOVE, 32'sh7fff_ffff);
        send_command(CMD_REMOVE, -32'sd1);
        send_command(CMD_REMOVE, 32'sd12345);
        while (board.held_count < CAPACITY)
            send_command(CMD_INSERT, value_pool[$urandom_range(POOL_N - 1)]);
        send_command(CMD_INSERT, 32'sh5555_aaaa);
        send_command(CMD_SHOW_FWD, 32'sd0);
        send_command(CMD_SHOW_REV, -32'sd1);

        // Random traffic under four idling patterns.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            foreach (value_pool[k]) value_pool[k] = $urandom;
            run_random(RANDOM_BEATS);
        end
        s_valid <= 1'b0;

        // Drain, then allow a show's worth of cycles for stray beats.
        while (board.pending_outcomes.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (board.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
